@@ hw/rtl/hwst_pkg.sv @@
`timescale 1ns / 1ps
package hwst_pkg;

  localparam int SAMPLES_DEF = 6;
  localparam int NUM_CODES   = 6;
  localparam int HALL_W      = 3;
  localparam int COUNT_W     = 8;
  localparam int FLAGS_W     = 6;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [FLAGS_W-1:0] SENSOR_ALL = 6'h07;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_EDGE  = 1'b1
  } hwst_cmd_t;

  typedef struct packed {
    hwst_cmd_t         cmd;
    logic [HALL_W-1:0] hall_code;
    logic              current_high;
    logic              motor_ccw;
  } hwst_item_t;

  typedef struct packed {
    logic               test_ready;
    logic [FLAGS_W-1:0] fault_flags;
  } hwst_result_t;

endpackage

@@ hw/rtl/hwst_core.sv @@
`timescale 1ns / 1ps
module hwst_core #(
  parameter int SAMPLES = hwst_pkg::SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  hwst_pkg::hwst_item_t item,
  output hwst_pkg::hwst_result_t res_nxt
);
  import hwst_pkg::*;

  localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);

  logic [HALL_W-1:0]  samples_r   [SAMPLES];
  logic [HALL_W-1:0]  samples_nxt [SAMPLES];
  logic [COUNT_W-1:0] counts_r    [NUM_CODES];
  logic [COUNT_W-1:0] counts_nxt  [NUM_CODES];
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ready_r, ready_nxt;
  logic               ccw_r, ccw_nxt;

  logic [HALL_W-1:0]    all_one, any_one, stuck;
  logic [NUM_CODES-1:0] hit;
  logic [3:0]           vote_a, vote_b, vote_c;
  logic [2:0]           wind;

  // State update for one request
  always_comb begin
    samples_nxt = samples_r;
    counts_nxt  = counts_r;
    idx_nxt     = idx_r;
    ready_nxt   = ready_r;
    ccw_nxt     = ccw_r;
    if (item.cmd == CMD_CLEAR) begin
      for (int i = 0; i < SAMPLES; i++) samples_nxt[i] = '0;
      for (int k = 0; k < NUM_CODES; k++) counts_nxt[k] = '0;
      idx_nxt   = '0;
      ready_nxt = 1'b0;
      ccw_nxt   = 1'b0;
    end else begin
      samples_nxt[idx_r] = item.hall_code;
      for (int k = 0; k < NUM_CODES; k++) begin
        // codes 0 and 7 match no counter; saturate at the top
        if (item.current_high && item.hall_code == HALL_W'(k + 1) &&
            counts_r[k] != COUNT_MAX) begin
          counts_nxt[k] = counts_r[k] + COUNT_W'(1);
        end
      end
      if (idx_r == IDX_LAST) begin
        idx_nxt   = '0;
        ready_nxt = 1'b1;
        ccw_nxt   = item.motor_ccw;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SAMPLES; i++) samples_r[i] <= '0;
      for (int k = 0; k < NUM_CODES; k++) counts_r[k] <= '0;
      idx_r   <= '0;
      ready_r <= 1'b0;
      ccw_r   <= 1'b0;
    end else if (upd) begin
      samples_r <= samples_nxt;
      counts_r  <= counts_nxt;
      idx_r     <= idx_nxt;
      ready_r   <= ready_nxt;
      ccw_r     <= ccw_nxt;
    end
  end

  // Fault word from the updated state
  always_comb begin
    all_one = '1;
    any_one = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      all_one = all_one & samples_nxt[i];
      any_one = any_one | samples_nxt[i];
    end
    stuck = all_one | ~any_one;

    for (int k = 0; k < NUM_CODES; k++) hit[k] = (counts_nxt[k] != '0);
    // each winding takes four votes; it is at fault with fewer than two hits
    vote_a = ccw_nxt ? {hit[2], hit[3], hit[0], hit[5]} : {hit[2], hit[3], hit[1], hit[4]};
    vote_b = ccw_nxt ? {hit[0], hit[5], hit[1], hit[4]} : {hit[0], hit[5], hit[2], hit[3]};
    vote_c = ccw_nxt ? {hit[1], hit[4], hit[2], hit[3]} : {hit[1], hit[4], hit[0], hit[5]};
    wind[2] = ($countones(vote_a) < 2);
    wind[1] = ($countones(vote_b) < 2);
    wind[0] = ($countones(vote_c) < 2);

    res_nxt.test_ready = ready_nxt;
    if (ready_nxt) begin
      res_nxt.fault_flags = {wind, stuck[0], stuck[1], stuck[2]};
    end else begin
      res_nxt.fault_flags = SENSOR_ALL;
    end
  end

endmodule

@@ hw/rtl/hall_winding_self_test.sv @@
`timescale 1ns / 1ps
// Hall sensor and winding self-test. A request with in_tuser low clears the
// test; with in_tuser high it is a hall edge that goes into a ring of SAMPLES
// codes and, with current present, bumps a saturating hit count for codes 1..6.
// Once SAMPLES such requests are in, test_ready rises and the direction is latched on
// every ring wrap. Each request returns one fault word. The block takes one
// request per clock while out_tready does not stall it; a result passes
// through the input register, then the ring update and fault evaluation
// into the result register, and the input register takes one more request
// while a result waits on out_tready.
module hall_winding_self_test #(
  parameter int SAMPLES = hwst_pkg::SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [2:0] hall_code, [3] current_high, [4] motor_ccw, [7:5] zero
  input  logic [hwst_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] test_ready, [6:1] fault_flags, [7] zero
  output logic [hwst_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hwst_pkg::*;

  logic         s1_valid_r;
  hwst_item_t   s1_item_r;
  logic         out_valid_r;
  hwst_result_t out_res_r;
  hwst_result_t res_nxt;
  logic         adv, upd;

  assign adv       = !out_valid_r || out_tready;
  assign upd       = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.cmd          <= hwst_cmd_t'(in_tuser);
      s1_item_r.hall_code    <= in_tdata[HALL_W-1:0];
      s1_item_r.current_high <= in_tdata[HALL_W];
      s1_item_r.motor_ccw    <= in_tdata[HALL_W+1];
    end
    if (upd) out_res_r <= res_nxt;
  end

  hwst_core #(
    .SAMPLES (SAMPLES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .item    (s1_item_r),
    .res_nxt (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.fault_flags, out_res_r.test_ready};

endmodule

@@ hw/rtl/hwst_checker.sv @@
`timescale 1ns / 1ps
module hwst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // before the test is ready all sensor faults are reported
  a_not_ready_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[6:1] == 6'h07)
    else $error("fault word wrong while not ready");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("pad bit set");

  // reset drops any result in flight
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the input side is never blocked while the output side is free
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("request refused with empty output");

endmodule

bind hall_winding_self_test hwst_checker u_hwst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
